[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/atrtp_pkg.sv]
// Package with the types and constants of the AT response terminator parser.
package atrtp_pkg;

	localparam int DEFAULT_BUFFER_DEPTH = 1024;
	localparam int BYTE_W = 8;
	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] MAX_BYTES_RESET = 11'd100;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_O = 8'h4F;
	localparam logic [BYTE_W-1:0] CH_K = 8'h4B;
	localparam logic [BYTE_W-1:0] CH_E = 8'h45;
	localparam logic [BYTE_W-1:0] CH_R = 8'h52;

	typedef enum logic [2:0] {
		PH_SCAN   = 3'b001,
		PH_OKWAIT = 3'b010,
		PH_TAIL   = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_OK    = 2'd1,
		ST_ERR   = 2'd2,
		ST_LIMIT = 2'd3
	} status_t;

endpackage

[src/atrtp_parser.sv]
// Parser state (match window, line-feed parity, phase, stored count) and per-byte result logic.
module atrtp_parser #(
	parameter int BUFFER_DEPTH = atrtp_pkg::DEFAULT_BUFFER_DEPTH,
	localparam int IW = $clog2(BUFFER_DEPTH),
	localparam int CW = $clog2(BUFFER_DEPTH + 2)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [atrtp_pkg::BYTE_W-1:0]   rx_byte,
	input  logic [atrtp_pkg::CFG_W-1:0]    max_bytes,
	output logic                           keep,
	output logic [IW-1:0]                  write_index,
	output logic                           last,
	output atrtp_pkg::status_t             status,
	output logic [CW-1:0]                  length
);
	import atrtp_pkg::*;

	localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BUFFER_DEPTH);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(BUFFER_DEPTH);
	localparam logic [CW-1:0] TWO = CW'(2);

	logic [BYTE_W-1:0] win_q [5];
	logic              par_q;
	phase_t            phase_q;
	logic [CW-1:0]     count_q;

	logic [BYTE_W-1:0] win_n [5];
	logic              par_n;
	phase_t            phase_n;
	logic [CW-1:0]     count_n;
	logic              clear;
	logic              drop;
	logic [CMP_W-1:0]  lim;
	logic              at_limit;

	// Effective limit is the smaller of the register and the buffer depth
	assign lim = (CMP_W'(max_bytes) > DEPTH_C) ? DEPTH_C : CMP_W'(max_bytes);

	// Shifted window: index 4 holds the newest byte
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			win_n[i] = win_q[i+1];
		end
		win_n[4] = rx_byte;
	end

	// Work out result and next state for one byte
	always_comb begin
		keep = 1'b0;
		write_index = '0;
		last = 1'b0;
		status = ST_RUN;
		length = '0;
		par_n = par_q;
		phase_n = phase_q;
		count_n = count_q;
		clear = 1'b0;
		drop = 1'b0;
		at_limit = 1'b0;
		unique case (phase_q)
			PH_OKWAIT: begin
				last = 1'b1;
				status = ST_OK;
				length = count_q;
				clear = 1'b1;
			end
			PH_TAIL: begin
				keep = 1'b1;
				write_index = count_q[IW-1:0];
				count_n = count_q + 1'b1;
				at_limit = CMP_W'(count_n) >= lim;
				if (win_q[4] == CH_CR && rx_byte == CH_LF) begin
					last = 1'b1;
					status = ST_ERR;
					length = (count_n >= TWO) ? count_n - TWO : '0;
					clear = 1'b1;
				end else if (at_limit) begin
					last = 1'b1;
					status = ST_LIMIT;
					length = count_n;
					clear = 1'b1;
				end
			end
			default: begin
				// Scanning, and any code that is not a phase
				par_n = par_q ^ (rx_byte == CH_LF);
				drop = (rx_byte == CH_LF && par_n) || rx_byte == CH_CR;
				if (!drop && count_q < DEPTH_CNT) begin
					keep = 1'b1;
					write_index = count_q[IW-1:0];
					count_n = count_q + 1'b1;
				end
				at_limit = CMP_W'(count_n) >= lim;
				priority if (win_n[2] == CH_O && win_n[3] == CH_K && win_n[4] == CH_CR) begin
					phase_n = PH_OKWAIT;
				end else if (win_n[0] == CH_E && win_n[1] == CH_R && win_n[2] == CH_R &&
						win_n[3] == CH_O && win_n[4] == CH_R) begin
					phase_n = PH_TAIL;
				end else if (at_limit) begin
					last = 1'b1;
					status = ST_LIMIT;
					length = count_n;
					clear = 1'b1;
				end else begin
					phase_n = PH_SCAN;
				end
			end
		endcase
	end

	// Advance the state on each processed beat; clear it after a response ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				win_q[i] <= '0;
			end
			par_q <= 1'b0;
			phase_q <= PH_SCAN;
			count_q <= '0;
		end else if (step) begin
			if (clear) begin
				for (int i = 0; i < 5; i++) begin
					win_q[i] <= '0;
				end
				par_q <= 1'b0;
				phase_q <= PH_SCAN;
				count_q <= '0;
			end else begin
				win_q <= win_n;
				par_q <= par_n;
				phase_q <= phase_n;
				count_q <= count_n;
			end
		end
	end

endmodule

[src/at_response_terminator_parser_top.sv]
// Top level of the AT response terminator parser: handshakes, input and result registers.
// Takes one received modem byte per beat and returns one result per byte: the byte echoed,
// whether and where it goes into the response buffer, and on the byte that ends a response
// (OK then CR and one more byte, ERROR then a tail up to CR LF, or the byte limit) the
// status and final length. One byte is accepted every cycle unless the output side stalls; each
// byte passes the input register, then the combinational window compare and count update into the
// result register, and a stalled output side holds one result while one more byte waits in the
// input register. The user must write the byte limit max_bytes (reset 100, capped at
// BUFFER_DEPTH) via the cfg channel only between responses; the block does not enforce it.
module at_response_terminator_parser_top #(
	parameter int BUFFER_DEPTH = atrtp_pkg::DEFAULT_BUFFER_DEPTH,
	localparam int IW = $clog2(BUFFER_DEPTH),
	localparam int CW = $clog2(BUFFER_DEPTH + 2)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [atrtp_pkg::BYTE_W-1:0]   rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [atrtp_pkg::BYTE_W-1:0]   data_byte,
	output logic                           keep,
	output logic [IW-1:0]                  write_index,
	output logic                           last,
	output logic [1:0]                     status,
	output logic [CW-1:0]                  length,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [atrtp_pkg::CFG_W-1:0]    cfg_data
);
	import atrtp_pkg::*;

	logic              in_valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic              advance;
	logic [CFG_W-1:0]  max_bytes_q;

	logic              keep_c;
	logic [IW-1:0]     widx_c;
	logic              last_c;
	status_t           status_c;
	logic [CW-1:0]     length_c;

	logic              out_valid_s2;
	logic [BYTE_W-1:0] data_byte_s2;
	logic              keep_s2;
	logic [IW-1:0]     widx_s2;
	logic              last_s2;
	status_t           status_s2;
	logic [CW-1:0]     length_s2;

	// Move the held byte on when the result register is free or draining
	assign advance = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Hold the byte limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_bytes_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	atrtp_parser #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (rx_byte_s1),
		.max_bytes   (max_bytes_q),
		.keep        (keep_c),
		.write_index (widx_c),
		.last        (last_c),
		.status      (status_c),
		.length      (length_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_byte_s2 <= rx_byte_s1;
			keep_s2 <= keep_c;
			widx_s2 <= widx_c;
			last_s2 <= last_c;
			status_s2 <= status_c;
			length_s2 <= length_c;
		end
	end

	assign out_valid = out_valid_s2;
	assign data_byte = data_byte_s2;
	assign keep = keep_s2;
	assign write_index = widx_s2;
	assign last = last_s2;
	assign status = status_s2;
	assign length = length_s2;

endmodule

[src/atrtp_checker.sv]
// Port-level checker for the AT response terminator parser, bound to the top level.
`include "assert_macros.svh"

module atrtp_checker #(
	parameter int BUFFER_DEPTH = atrtp_pkg::DEFAULT_BUFFER_DEPTH,
	localparam int IW = $clog2(BUFFER_DEPTH),
	localparam int CW = $clog2(BUFFER_DEPTH + 2)
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [atrtp_pkg::BYTE_W-1:0]   data_byte,
	input logic                           keep,
	input logic [IW-1:0]                  write_index,
	input logic                           last,
	input logic [1:0]                     status,
	input logic [CW-1:0]                  length
);
	import atrtp_pkg::*;

	// Stalled result beat keeps its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(data_byte) && $stable(keep) && $stable(write_index) && $stable(last) && $stable(status) && $stable(length))

	// Beats that do not end a response carry no status and no length
	`ASSERT_SAME(a_run_clean, clk, arst_n, out_valid && !last, status == ST_RUN && length == '0)

	// Ending beat always names how the response ended
	`ASSERT_SAME(a_last_status, clk, arst_n, out_valid && last, status != ST_RUN)

	// Dropped bytes carry no buffer position
	`ASSERT_SAME(a_drop_index, clk, arst_n, out_valid && !keep, write_index == '0)

endmodule

bind at_response_terminator_parser_top atrtp_checker #(
	.BUFFER_DEPTH(BUFFER_DEPTH)
) u_atrtp_checker (.*);
